>>> src/ibst_pkg.sv
package ibst_pkg;

	localparam int SLOTS_DEF = 63;
	localparam int KEY_W = 32;
	localparam int SLOT_W = 6;
	localparam int STATUS_W = 3;
	localparam int OP_W = 2;
	localparam int TREE_H = 6;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DUMP = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_DUP = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ITEM = 3'd3;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd5;

	localparam logic [SLOT_W-1:0] FULL_SLOT = 6'd63;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic signed [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic signed [KEY_W-1:0] out_key;
		logic [SLOT_W-1:0] slot;
		logic last;
	} rsp_t;

	// map an in-order rank (1-based) of a perfect tree to its heap slot
	function automatic logic [SLOT_W-1:0] inorder_slot(input logic [SLOT_W-1:0] rank);
		logic [2:0] tz;
		logic found;
		logic [SLOT_W:0] heap;
		tz = 3'd0;
		found = 1'b0;
		for (int b = 0; b < SLOT_W; b++) begin
			if (!found) begin
				if (rank[b]) begin
					found = 1'b1;
				end else begin
					tz = tz + 3'd1;
				end
			end
		end
		heap = ((SLOT_W+1)'(1) << (3'(TREE_H - 1) - tz)) + (SLOT_W+1)'(rank >> (tz + 3'd1));
		return SLOT_W'(heap - (SLOT_W+1)'(1));
	endfunction

endpackage

>>> src/ibst_key_ram.sv
module ibst_key_ram #(
	parameter int DEPTH = ibst_pkg::SLOTS_DEF,
	parameter int AW = 6
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic signed [ibst_pkg::KEY_W-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic signed [ibst_pkg::KEY_W-1:0] rdata
);

	logic signed [ibst_pkg::KEY_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/implicit_bst_insert_and_inorder_core.sv
// Binary search tree in SLOTS slots with implicit children 2i+1 / 2i+2, keys held in a
// single-port-read RAM and compared for equality and signed order against the request
// key. An insert checks the slot's used bit in S_INS_CHK and compares against the key
// read from RAM in S_INS_CMP at each level, and reports full once the index runs past
// the last slot; it can also wait on the result register. A dump steps a rank counter
// through the in-order positions of the tree, passing over empty positions and emitting
// one result per stored key; it is bounded by the one RAM read a cycle and can stall on
// the result register. Clear and an empty dump go straight to S_SOLO for their single
// result. The block takes no new request until the current one has issued its last
// result, but the result register lets it take that request while the last result waits.
module implicit_bst_insert_and_inorder_core #(
	parameter int SLOTS = ibst_pkg::SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input ibst_pkg::req_t req,
	output logic rsp_valid,
	input logic rsp_ready,
	output ibst_pkg::rsp_t rsp
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int IW = $clog2(2 * SLOTS + 1);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int SW = ibst_pkg::SLOT_W;
	localparam int KW = ibst_pkg::KEY_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_INS_CHK = 6'b000010,
		S_INS_CMP = 6'b000100,
		S_DMP_SCAN = 6'b001000,
		S_DMP_EMIT = 6'b010000,
		S_SOLO = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [SLOTS-1:0] used_q;
	logic [CW-1:0] used_cnt_q;
	logic [CW-1:0] emit_cnt_q;
	logic [IW-1:0] idx_q;
	logic signed [KW-1:0] key_q;
	logic [SW-1:0] rank_q;
	logic [SW-1:0] slot_q;
	logic [ibst_pkg::STATUS_W-1:0] solo_status_q;
	logic rsp_valid_q;
	ibst_pkg::rsp_t rsp_q;

	logic req_xfer;
	logic out_free;
	logic out_load;
	ibst_pkg::rsp_t out_d;
	logic ram_we;
	logic [AW-1:0] ram_raddr;
	logic signed [KW-1:0] ram_rdata;
	logic [SW-1:0] dmp_idx;
	logic dmp_hit;
	logic ins_full;
	logic ins_free;
	logic dmp_last;

	assign req_ready = (state_q == S_IDLE);
	assign req_xfer = req_valid && req_ready;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	assign dmp_idx = ibst_pkg::inorder_slot(rank_q);
	assign dmp_hit = (dmp_idx < SW'(SLOTS)) && used_q[dmp_idx[AW-1:0]];
	assign ins_full = (idx_q >= IW'(SLOTS));
	assign ins_free = !used_q[idx_q[AW-1:0]];
	assign dmp_last = (CW'(emit_cnt_q + 1'b1) == used_cnt_q);

	always_comb begin
		case (state_q)
			S_INS_CHK, S_INS_CMP: ram_raddr = idx_q[AW-1:0];
			S_DMP_SCAN: ram_raddr = dmp_idx[AW-1:0];
			default: ram_raddr = slot_q[AW-1:0];
		endcase
	end

	assign ram_we = (state_q == S_INS_CHK) && !ins_full && ins_free && out_free;

	ibst_key_ram #(
		.DEPTH(SLOTS),
		.AW(AW)
	) u_key_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(idx_q[AW-1:0]),
		.wdata(key_q),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		out_load = 1'b0;
		out_d = '{status: ibst_pkg::ST_INSERTED, out_key: key_q,
			slot: SW'(idx_q[AW-1:0]), last: 1'b1};
		case (state_q)
			S_IDLE: begin
				if (req_xfer) begin
					case (req.op)
						ibst_pkg::OP_INSERT: state_d = S_INS_CHK;
						ibst_pkg::OP_DUMP: state_d = (used_cnt_q == '0) ? S_SOLO : S_DMP_SCAN;
						ibst_pkg::OP_CLEAR: state_d = S_SOLO;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_INS_CHK: begin
				if (ins_full) begin
					out_d.status = ibst_pkg::ST_FULL;
					out_d.slot = ibst_pkg::FULL_SLOT;
					if (out_free) begin
						out_load = 1'b1;
						state_d = S_IDLE;
					end
				end else if (ins_free) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				out_d.status = ibst_pkg::ST_DUP;
				if (ram_rdata == key_q) begin
					if (out_free) begin
						out_load = 1'b1;
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_INS_CHK;
				end
			end
			S_DMP_SCAN: begin
				if (dmp_hit) begin
					state_d = S_DMP_EMIT;
				end
			end
			S_DMP_EMIT: begin
				out_d = '{status: ibst_pkg::ST_ITEM, out_key: ram_rdata, slot: slot_q,
					last: dmp_last};
				if (out_free) begin
					out_load = 1'b1;
					state_d = dmp_last ? S_IDLE : S_DMP_SCAN;
				end
			end
			S_SOLO: begin
				out_d = '{status: solo_status_q, out_key: '0, slot: '0, last: 1'b1};
				if (out_free) begin
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			used_cnt_q <= '0;
			emit_cnt_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (req_xfer && (req.op == ibst_pkg::OP_CLEAR)) begin
				used_q <= '0;
				used_cnt_q <= '0;
			end else if (ram_we) begin
				used_q[idx_q[AW-1:0]] <= 1'b1;
				used_cnt_q <= CW'(used_cnt_q + 1'b1);
			end
			if (req_xfer) begin
				emit_cnt_q <= '0;
			end else if ((state_q == S_DMP_EMIT) && out_load) begin
				emit_cnt_q <= CW'(emit_cnt_q + 1'b1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_q <= out_d;
		end
		if (req_xfer) begin
			key_q <= req.key;
			idx_q <= '0;
			rank_q <= SW'(1);
			solo_status_q <= (req.op == ibst_pkg::OP_CLEAR) ? ibst_pkg::ST_CLEARED
				: ibst_pkg::ST_EMPTY;
		end else begin
			if ((state_q == S_INS_CMP) && (ram_rdata != key_q)) begin
				idx_q <= (key_q < ram_rdata) ? IW'({idx_q[IW-2:0], 1'b0} + IW'(1))
					: IW'({idx_q[IW-2:0], 1'b0} + IW'(2));
			end
			if ((state_q == S_DMP_SCAN) && dmp_hit) begin
				slot_q <= dmp_idx;
			end
			if (((state_q == S_DMP_SCAN) && !dmp_hit)
				|| ((state_q == S_DMP_EMIT) && out_load)) begin
				rank_q <= SW'(rank_q + 1'b1);
			end
		end
	end

`ifndef SYNTH
	assert property (@(posedge clk) disable iff (!arst_n)
		used_cnt_q == CW'($countones(used_q)))
		else $error("used count out of step with used bits");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (out_d.status == ibst_pkg::ST_INSERTED))
		|=> (used_cnt_q == CW'($past(used_cnt_q) + 1'b1)))
		else $error("insert result without a slot taken");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && (out_d.status == ibst_pkg::ST_ITEM) && out_d.last)
		|=> (state_q == S_IDLE))
		else $error("dump continued past its last key");
`endif

endmodule

>>> dv/tb_implicit_bst_insert_and_inorder_core.sv
module tb_implicit_bst_insert_and_inorder_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KW = ibst_pkg::KEY_W;
	localparam logic [ibst_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int N_SLOTS = ibst_pkg::SLOTS_DEF;
	localparam int TARGET_ITEMS = 106;
	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 150;
	localparam logic signed [KW-1:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [KW-1:0] KEY_MAX = 32'sh7FFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	ibst_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	ibst_pkg::rsp_t rsp;

	ibst_pkg::req_t req_backlog[$];
	ibst_pkg::rsp_t rsp_expected[$];
	logic signed [KW-1:0] tree_key [N_SLOTS];
	bit tree_used [N_SLOTS];
	int n_total = 0;
	int n_taken = 0;
	int n_err = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int phase = 0;

	implicit_bst_insert_and_inorder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit idle_now(bit sender);
		case (phase)
			1: return sender && ($urandom_range(99) < 77);
			2: return !sender && ($urandom_range(99) < 77);
			3: return $urandom_range(99) < 37;
			default: return 1'b0;
		endcase
	endfunction

	function automatic ibst_pkg::rsp_t make_rsp(logic [ibst_pkg::STATUS_W-1:0] status,
			logic signed [KW-1:0] k, int slot, bit last);
		ibst_pkg::rsp_t r;
		r.status = status;
		r.out_key = k;
		r.slot = ibst_pkg::SLOT_W'(slot);
		r.last = last;
		return r;
	endfunction

	task automatic report(string msg);
		n_err++;
		if (n_err <= 100) begin
			$display("mismatch at %0t: %s", $realtime, msg);
		end
	endtask

	// walk the mirrored tree for one accepted request and queue its results
	task automatic tree_apply(ibst_pkg::req_t r);
		int i;
		int n;
		int rank;
		int tz;
		int s;
		int a;
		bit reach;
		bit done;
		ibst_pkg::rsp_t res;
		logic signed [KW-1:0] k;
		k = $signed(r.key);
		case (r.op)
			ibst_pkg::OP_INSERT: begin
				i = 0;
				done = 1'b0;
				res = make_rsp(ibst_pkg::ST_FULL, k, ibst_pkg::FULL_SLOT, 1'b1);
				while (!done && i < N_SLOTS) begin
					if (!tree_used[i]) begin
						tree_used[i] = 1'b1;
						tree_key[i] = k;
						res = make_rsp(ibst_pkg::ST_INSERTED, k, i, 1'b1);
						done = 1'b1;
					end else if (k == tree_key[i]) begin
						res = make_rsp(ibst_pkg::ST_DUP, k, i, 1'b1);
						done = 1'b1;
					end else if (k < tree_key[i]) begin
						i = 2 * i + 1;
					end else begin
						i = 2 * i + 2;
					end
				end
				rsp_expected.push_back(res);
			end
			ibst_pkg::OP_DUMP: begin
				n = 0;
				for (rank = 1; rank <= N_SLOTS; rank++) begin
					tz = 0;
					while (((rank >> tz) & 1) == 0) begin
						tz++;
					end
					s = (1 << (ibst_pkg::TREE_H - 1 - tz)) - 1 + (rank >> (tz + 1));
					reach = tree_used[s];
					a = s;
					while (reach && a > 0) begin
						a = (a - 1) / 2;
						reach = tree_used[a];
					end
					if (reach) begin
						rsp_expected.push_back(make_rsp(ibst_pkg::ST_ITEM, tree_key[s], s,
							1'b0));
						n++;
					end
				end
				if (n == 0) begin
					rsp_expected.push_back(make_rsp(ibst_pkg::ST_EMPTY, '0, 0, 1'b1));
				end else begin
					res = rsp_expected.pop_back();
					res.last = 1'b1;
					rsp_expected.push_back(res);
				end
			end
			ibst_pkg::OP_CLEAR: begin
				for (i = 0; i < N_SLOTS; i++) begin
					tree_used[i] = 1'b0;
				end
				rsp_expected.push_back(make_rsp(ibst_pkg::ST_CLEARED, '0, 0, 1'b1));
			end
			default: begin
			end
		endcase
	endtask

	task automatic add(logic [ibst_pkg::OP_W-1:0] op, logic [KW-1:0] k);
		ibst_pkg::req_t r;
		r.op = op;
		r.key = k;
		req_backlog.push_back(r);
		n_total++;
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			phase <= (n_total == 0) ? 0 : ((n_total - req_backlog.size()) * 4) / n_total;
			if (!req_valid || req_ready) begin
				if (req_backlog.size() > 0 && !idle_now(1'b1)) begin
					req <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// hold off once for a long stretch so the core backs up into its input
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && rsp_valid) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= !idle_now(1'b0);
		end
	end

	always @(posedge clk) begin : monitor
		ibst_pkg::rsp_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				tree_apply(req);
				n_taken++;
			end
			if (rsp_valid && rsp_ready) begin
				if (rsp_expected.size() == 0) begin
					report($sformatf("result with nothing expected: status %0d key %0d slot %0d",
						rsp.status, $signed(rsp.out_key), rsp.slot));
				end else begin
					want = rsp_expected.pop_front();
					if (rsp.status !== want.status)
						report($sformatf("status %0d, expected %0d", rsp.status, want.status));
					if (rsp.out_key !== want.out_key)
						report($sformatf("out_key %0d, expected %0d",
							$signed(rsp.out_key), $signed(want.out_key)));
					if (rsp.slot !== want.slot)
						report($sformatf("slot %0d, expected %0d", rsp.slot, want.slot));
					if (rsp.last !== want.last)
						report($sformatf("last %0d, expected %0d", rsp.last, want.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int s;
		int d;
		int p;
		int rank;
		int base;
		int stride;
		int len;
		int j;
		int pick;
		int k0;
		bit chain;
		logic [KW-1:0] k;

		add(ibst_pkg::OP_DUMP, 32'hFFFF_FFFF);
		add(ibst_pkg::OP_INSERT, 32'd0);
		add(ibst_pkg::OP_INSERT, 32'd0);
		add(ibst_pkg::OP_INSERT, KEY_MIN);
		add(ibst_pkg::OP_INSERT, KEY_MAX);
		add(ibst_pkg::OP_INSERT, 32'hFFFF_FFFF);
		add(ibst_pkg::OP_INSERT, 32'd1);
		add(ibst_pkg::OP_DUMP, 32'h0);
		add(OP_UNUSED, 32'hFFFF_FFFF);
		add(ibst_pkg::OP_INSERT, KEY_MAX);
		add(ibst_pkg::OP_CLEAR, 32'h5555_AAAA);
		add(ibst_pkg::OP_DUMP, 32'h0);
		for (j = 1; j <= 7; j++) begin
			add(ibst_pkg::OP_INSERT, 32'(j * 10));
		end
		add(ibst_pkg::OP_INSERT, 32'd5);
		add(ibst_pkg::OP_DUMP, 32'h0);
		add(ibst_pkg::OP_CLEAR, 32'h0);

		// a full, perfectly balanced tree inserted in level order
		base = $signed($urandom) >>> 1;
		stride = $urandom_range(1, 1000);
		for (s = 0; s < N_SLOTS; s++) begin
			d = $clog2(s + 2) - 1;
			p = s + 1 - (1 << d);
			rank = (2 * p + 1) << (ibst_pkg::TREE_H - 1 - d);
			add(ibst_pkg::OP_INSERT, 32'(base + stride * rank));
		end
		add(ibst_pkg::OP_DUMP, $urandom);
		add(ibst_pkg::OP_INSERT, $urandom);
		add(ibst_pkg::OP_INSERT, 32'(base + stride * $urandom_range(1, N_SLOTS)));

		while (n_total < TARGET_ITEMS) begin
			add(ibst_pkg::OP_CLEAR, $urandom);
			chain = ($urandom_range(9) == 0);
			len = chain ? 8 : $urandom_range(1, 20);
			k0 = $urandom_range(0, 1000) - 500;
			for (j = 0; j < len; j++) begin
				pick = $urandom_range(99);
				if (chain) begin
					k = 32'(k0 + j * 7);
				end else if (pick < 40) begin
					k = 32'($urandom_range(0, 15) - 8);
				end else if (pick < 80) begin
					k = $urandom;
				end else if (pick < 90) begin
					k = pick[0] ? KEY_MIN : KEY_MAX;
				end else begin
					k = $urandom;
				end
				if (!chain && pick >= 95) begin
					add(ibst_pkg::OP_DUMP, k);
				end else if (!chain && pick >= 90) begin
					add(OP_UNUSED, k);
				end else begin
					add(ibst_pkg::OP_INSERT, k);
				end
			end
			add(ibst_pkg::OP_DUMP, $urandom);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		while (n_taken < n_total || rsp_expected.size() > 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (n_err == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/ibst_pkg.sv
src/ibst_key_ram.sv
src/implicit_bst_insert_and_inorder_core.sv
dv/tb_implicit_bst_insert_and_inorder_core.sv
